// ===== design/blc_pkg.sv =====
// shared constants, types and log2 helpers for the blackbody color sampler
`default_nettype none
package blc_pkg;

   localparam int TEMP_W     = 16;
   localparam int CHAN_W     = 16;
   localparam int MANT_W     = 17;
   localparam int FRAC_W     = 16;
   localparam int EXP_W      = 4;
   localparam int LOG_W      = EXP_W + FRAC_W;
   localparam int ENTRIES_W  = 9;
   localparam int INDEX_W    = 8;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;
   localparam int TABLE_DEPTH_DEF = 256;

   localparam logic [CHAN_W-1:0]    WHITE_LEVEL   = 16'd32768;
   localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 9'd256;
   localparam logic [TEMP_W-1:0]    TLOW_RESET    = 16'd1000;
   localparam logic [TEMP_W-1:0]    THIGH_RESET   = 16'd40000;

   // register indexes
   localparam logic [1:0] REG_ENTRIES = 2'd0;
   localparam logic [1:0] REG_TLOW    = 2'd1;
   localparam logic [1:0] REG_THIGH   = 2'd2;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic                bit_out;
      logic [MANT_W-1:0]   mant;
   } sq_type;

   // position of the leading one, zero for zero
   function automatic logic [EXP_W-1:0] lead_one(input logic [TEMP_W-1:0] x);
      logic [EXP_W-1:0] e;
      e = '0;
      for (int i = 1; i < TEMP_W; i++) begin
         if (x[i]) e = EXP_W'(i);
      end
      return e;
   endfunction

   // mantissa normalized to Q1.16
   function automatic logic [MANT_W-1:0] norm_mant(input logic [TEMP_W-1:0] x,
                                                   input logic [EXP_W-1:0] e);
      logic [32:0] tmp;
      tmp = {17'd0, x} << (5'd16 - {1'b0, e});
      return tmp[MANT_W-1:0];
   endfunction

   // one squaring step yielding one fraction bit
   function automatic sq_type sq_step(input logic [MANT_W-1:0] m);
      logic [2*MANT_W-1:0] p;
      sq_type r;
      p = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
      r.bit_out = p[33];
      r.mant    = p[33] ? p[33:17] : p[32:16];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/blackbody_color_lut_sampler_top.sv =====
// blackbody color sampler: log2 position, pipelined divide and table blend
// throughput: one item per cycle while busy is low; the squaring and divide chains are fully pipelined
// busy is high while log2 of the range limits is recomputed after reset or a
// limit write, on a shared squaring unit
// synchronous reset restores the register defaults; table contents stay undefined
`default_nettype none
module blackbody_color_lut_sampler_top #(
   parameter int TABLE_DEPTH = blc_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_kind,
   input  wire logic [blc_pkg::INDEX_W-1:0]   req_entry_index,
   input  wire logic [blc_pkg::CHAN_W-1:0]    req_entry_red,
   input  wire logic [blc_pkg::CHAN_W-1:0]    req_entry_green,
   input  wire logic [blc_pkg::CHAN_W-1:0]    req_entry_blue,
   input  wire logic [blc_pkg::TEMP_W-1:0]    req_temperature,
   output logic                               rsp_strobe,
   output logic [blc_pkg::CHAN_W-1:0]         rsp_red,
   output logic [blc_pkg::CHAN_W-1:0]         rsp_green,
   output logic [blc_pkg::CHAN_W-1:0]         rsp_blue,
   output logic                               rsp_fallback_white,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [blc_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [blc_pkg::DATA_W-1:0]    pwdata,
   output logic [blc_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);
   import blc_pkg::*;

   localparam int IW   = $clog2(TABLE_DEPTH);
   localparam int QW   = IW + 16;
   localparam int XW   = (IW > INDEX_W) ? IW : INDEX_W;
   localparam int ADDR_ST = 21 + QW;
   localparam int LAST = 23 + QW;
   localparam int SQ_N = 16;

   localparam logic [1:0] CAL_IDLE  = 2'd0;
   localparam logic [1:0] CAL_START = 2'd1;
   localparam logic [1:0] CAL_LOW   = 2'd2;
   localparam logic [1:0] CAL_HIGH  = 2'd3;

   typedef struct packed {
      logic                      valid;
      logic                      sample;
      logic                      white;
      logic [INDEX_W-1:0]        idx;
      logic [3*CHAN_W-1:0]       rgb;
   } ctl_type;

   // configuration registers
   logic [ENTRIES_W-1:0] entries_ff;
   logic [TEMP_W-1:0]    tlow_ff, thigh_ff;
   logic [LOG_W-1:0]     llo_ff, lhi_ff;
   logic                 cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= ENTRIES_RESET;
         tlow_ff    <= TLOW_RESET;
         thigh_ff   <= THIGH_RESET;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_ENTRIES: entries_ff <= pwdata[ENTRIES_W-1:0];
            REG_TLOW:    tlow_ff    <= pwdata[TEMP_W-1:0];
            REG_THIGH:   thigh_ff   <= pwdata[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back
   always_comb begin
      case (paddr[3:2])
         REG_ENTRIES: prdata = {{(DATA_W-ENTRIES_W){1'b0}}, entries_ff};
         REG_TLOW:    prdata = {{(DATA_W-TEMP_W){1'b0}}, tlow_ff};
         REG_THIGH:   prdata = {{(DATA_W-TEMP_W){1'b0}}, thigh_ff};
         default:     prdata = '0;
      endcase
   end

   // log2 of the range limits on one shared squaring unit
   logic [1:0]        cal_state_ff, cal_state_in;
   logic [3:0]        cal_cnt_ff;
   logic [MANT_W-1:0] cal_m_ff;
   logic [FRAC_W-1:0] cal_f_ff;
   logic [EXP_W-1:0]  cal_e_ff;
   sq_type            cal_sq;
   logic [EXP_W-1:0]  high_e;

   assign cal_sq = sq_step(cal_m_ff);
   assign high_e = lead_one(thigh_ff);
   assign busy   = (cal_state_ff != CAL_IDLE);

   always_comb begin
      cal_state_in = cal_state_ff;
      case (cal_state_ff)
         CAL_IDLE:  cal_state_in = CAL_IDLE;
         CAL_START: cal_state_in = CAL_LOW;
         CAL_LOW:   if (cal_cnt_ff == 4'd15) cal_state_in = CAL_HIGH;
         CAL_HIGH:  if (cal_cnt_ff == 4'd15) cal_state_in = CAL_IDLE;
         default:   cal_state_in = CAL_IDLE;
      endcase
      if (cfg_wr && (paddr[3:2] == REG_TLOW || paddr[3:2] == REG_THIGH))
         cal_state_in = CAL_START;
   end

   always_ff @(posedge clock) begin
      if (reset) cal_state_ff <= CAL_START;
      else       cal_state_ff <= cal_state_in;
   end

   always_ff @(posedge clock) begin
      case (cal_state_ff)
         CAL_START: begin
            cal_e_ff   <= lead_one(tlow_ff);
            cal_m_ff   <= norm_mant(tlow_ff, lead_one(tlow_ff));
            cal_f_ff   <= '0;
            cal_cnt_ff <= '0;
         end
         CAL_LOW, CAL_HIGH: begin
            cal_cnt_ff <= cal_cnt_ff + 4'd1;
            if (cal_cnt_ff == 4'd15 && cal_state_ff == CAL_LOW) begin
               // low limit done, load the high limit
               llo_ff   <= {cal_e_ff, cal_f_ff[FRAC_W-2:0], cal_sq.bit_out};
               cal_e_ff <= high_e;
               cal_m_ff <= norm_mant(thigh_ff, high_e);
               cal_f_ff <= '0;
            end else begin
               cal_f_ff <= {cal_f_ff[FRAC_W-2:0], cal_sq.bit_out};
               cal_m_ff <= cal_sq.mant;
               if (cal_cnt_ff == 4'd15)
                  lhi_ff <= {cal_e_ff, cal_f_ff[FRAC_W-2:0], cal_sq.bit_out};
            end
         end
         default: ;
      endcase
   end

   // degenerate setup detection
   logic                  degen;
   logic [LOG_W-1:0]      span;
   logic [IW-1:0]         nm1;
   logic [ENTRIES_W-1:0]  entries_m1;

   assign degen = (entries_ff < 9'd2) || (32'(entries_ff) > TABLE_DEPTH) ||
                  (tlow_ff == '0) || (thigh_ff <= tlow_ff) || (lhi_ff <= llo_ff);
   assign span       = lhi_ff - llo_ff;
   assign entries_m1 = entries_ff - 9'd1;
   assign nm1        = IW'(entries_m1);

   // control line, valid bits under reset
   ctl_type ctl_ff [0:LAST];
   logic    accept;

   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) ctl_ff[k].valid <= 1'b0;
      end else begin
         ctl_ff[0].valid <= accept;
         for (int k = 1; k <= LAST; k++) ctl_ff[k].valid <= ctl_ff[k-1].valid;
      end
      ctl_ff[0].sample <= (req_kind == KIND_SAMPLE);
      ctl_ff[0].white  <= degen;
      ctl_ff[0].idx    <= req_entry_index;
      ctl_ff[0].rgb    <= {req_entry_red, req_entry_green, req_entry_blue};
      for (int k = 1; k <= LAST; k++) begin
         ctl_ff[k].sample <= ctl_ff[k-1].sample;
         ctl_ff[k].white  <= ctl_ff[k-1].white;
         ctl_ff[k].idx    <= ctl_ff[k-1].idx;
         ctl_ff[k].rgb    <= ctl_ff[k-1].rgb;
      end
   end

   // clamp temperature
   logic [TEMP_W-1:0] t_in, t_ff;
   always_comb begin
      t_in = req_temperature;
      if (t_in < tlow_ff)  t_in = tlow_ff;
      if (t_in > thigh_ff) t_in = thigh_ff;
   end
   always_ff @(posedge clock) t_ff <= t_in;

   // normalize and square chain
   logic [MANT_W-1:0] sq_m_ff [0:SQ_N];
   logic [FRAC_W-1:0] sq_f_ff [0:SQ_N];
   logic [EXP_W-1:0]  sq_e_ff [0:SQ_N];
   sq_type            sq_res [1:SQ_N];

   always_comb begin
      for (int k = 1; k <= SQ_N; k++) sq_res[k] = sq_step(sq_m_ff[k-1]);
   end

   always_ff @(posedge clock) begin
      sq_e_ff[0] <= lead_one(t_ff);
      sq_m_ff[0] <= norm_mant(t_ff, lead_one(t_ff));
      sq_f_ff[0] <= '0;
      for (int k = 1; k <= SQ_N; k++) begin
         sq_e_ff[k] <= sq_e_ff[k-1];
         sq_m_ff[k] <= sq_res[k].mant;
         sq_f_ff[k] <= {sq_f_ff[k-1][FRAC_W-2:0], sq_res[k].bit_out};
      end
   end

   // offset from the low limit, then scale by entry count minus one
   logic [LOG_W-1:0]    diff_ff;
   logic [LOG_W+IW-1:0] prod_ff;
   always_ff @(posedge clock) begin
      diff_ff <= {sq_e_ff[SQ_N], sq_f_ff[SQ_N]} - llo_ff;
      prod_ff <= {{IW{1'b0}}, diff_ff} * {{LOG_W{1'b0}}, nm1};
   end

   // restoring divide, one quotient bit per stage
   logic [LOG_W-1:0] rem_ff [0:QW];
   logic [QW-1:0]    quo_ff [0:QW];
   logic [QW-1:0]    low_ff [0:QW];
   logic [LOG_W:0]   trial [1:QW];

   always_comb begin
      for (int k = 1; k <= QW; k++) trial[k] = {rem_ff[k-1], low_ff[k-1][QW-1]};
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= prod_ff[LOG_W+IW-1:IW];
      low_ff[0] <= {prod_ff[IW-1:0], 16'd0};
      quo_ff[0] <= '0;
      for (int k = 1; k <= QW; k++) begin
         low_ff[k] <= {low_ff[k-1][QW-2:0], 1'b0};
         if (trial[k] >= {1'b0, span}) begin
            rem_ff[k] <= LOG_W'(trial[k] - {1'b0, span});
            quo_ff[k] <= {quo_ff[k-1][QW-2:0], 1'b1};
         end else begin
            rem_ff[k] <= trial[k][LOG_W-1:0];
            quo_ff[k] <= {quo_ff[k-1][QW-2:0], 1'b0};
         end
      end
   end

   // entry addresses and weight
   logic [IW-1:0] lower_raw, lower_in, upper_in;
   logic [IW-1:0] lower_ff, upper_ff;
   logic [15:0]   w_ff, w2_ff;

   assign lower_raw = quo_ff[QW][QW-1:16];
   assign lower_in  = (lower_raw > nm1) ? nm1 : lower_raw;
   assign upper_in  = (lower_in == nm1) ? nm1 : lower_in + IW'(1);

   always_ff @(posedge clock) begin
      lower_ff <= lower_in;
      upper_ff <= upper_in;
      w_ff     <= quo_ff[QW][15:0];
      w2_ff    <= w_ff;
   end

   // color table, loads write in the same stage that samples read
   logic [3*CHAN_W-1:0] color_mem [0:TABLE_DEPTH-1];
   logic [3*CHAN_W-1:0] rd_lo_ff, rd_hi_ff;
   logic [XW-1:0]       ld_idx;
   logic                ld_en;

   assign ld_idx = XW'(ctl_ff[ADDR_ST].idx);
   assign ld_en  = ctl_ff[ADDR_ST].valid && !ctl_ff[ADDR_ST].sample &&
                   (32'(ld_idx) < TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (ld_en) color_mem[ld_idx[IW-1:0]] <= ctl_ff[ADDR_ST].rgb;
      rd_lo_ff <= color_mem[lower_ff];
      rd_hi_ff <= color_mem[upper_ff];
   end

   // blend: a + floor((b - a) * w / 65536)
   logic signed [CHAN_W:0]     dch [0:2];
   logic signed [2*CHAN_W+1:0] bl_ff [0:2];
   logic [CHAN_W-1:0]          a_ff [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++)
         dch[c] = $signed({1'b0, rd_hi_ff[(2-c)*CHAN_W +: CHAN_W]}) -
                  $signed({1'b0, rd_lo_ff[(2-c)*CHAN_W +: CHAN_W]});
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         a_ff[c]  <= rd_lo_ff[(2-c)*CHAN_W +: CHAN_W];
         bl_ff[c] <= dch[c] * $signed({1'b0, w2_ff});
      end
   end

   // result registers
   logic [CHAN_W+1:0] sum [0:2];
   always_comb begin
      for (int c = 0; c < 3; c++)
         sum[c] = {2'b00, a_ff[c]} + bl_ff[c][2*CHAN_W+1:CHAN_W];
   end

   logic              strobe_ff;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic              white_ff;

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= ctl_ff[LAST].valid & ctl_ff[LAST].sample;
   end

   always_ff @(posedge clock) begin
      white_ff <= ctl_ff[LAST].white;
      red_ff   <= ctl_ff[LAST].white ? WHITE_LEVEL : sum[0][CHAN_W-1:0];
      green_ff <= ctl_ff[LAST].white ? WHITE_LEVEL : sum[1][CHAN_W-1:0];
      blue_ff  <= ctl_ff[LAST].white ? WHITE_LEVEL : sum[2][CHAN_W-1:0];
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_red            = red_ff;
   assign rsp_green          = green_ff;
   assign rsp_blue           = blue_ff;
   assign rsp_fallback_white = white_ff;

endmodule
`default_nettype wire

// ===== tb/blackbody_color_lut_sampler_top_tb.sv =====
// self-checking testbench for the blackbody color table sampler
`timescale 1ns / 100ps
module blackbody_color_lut_sampler_top_tb;
   import blc_pkg::*;

   localparam int DEPTH      = 256;
   localparam int LATENCY    = 60;
   localparam int RAND_ITEMS = 115;

   typedef struct {
      logic                kind;
      logic [INDEX_W-1:0]  index;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
      logic [TEMP_W-1:0]   temp;
   } lut_item_type;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              white;
   } color_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = 1'b0;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic [CHAN_W-1:0]  req_entry_red = '0;
   logic [CHAN_W-1:0]  req_entry_green = '0;
   logic [CHAN_W-1:0]  req_entry_blue = '0;
   logic [TEMP_W-1:0]  req_temperature = '0;
   logic rsp_strobe;
   logic [CHAN_W-1:0] rsp_red, rsp_green, rsp_blue;
   logic rsp_fallback_white;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   blackbody_color_lut_sampler_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_entry_index(req_entry_index),
      .req_entry_red(req_entry_red), .req_entry_green(req_entry_green),
      .req_entry_blue(req_entry_blue), .req_temperature(req_temperature),
      .rsp_strobe(rsp_strobe), .rsp_red(rsp_red), .rsp_green(rsp_green),
      .rsp_blue(rsp_blue), .rsp_fallback_white(rsp_fallback_white),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lut_item_type pending_q[$];
   color_type    color_q[$];
   int           idle_pct = 10;
   int           errors = 0;

   // predictor state
   logic [CHAN_W-1:0]    shadow_table [DEPTH][3];
   logic [ENTRIES_W-1:0] cfg_entries = ENTRIES_RESET;
   logic [TEMP_W-1:0]    cfg_tlow    = TLOW_RESET;
   logic [TEMP_W-1:0]    cfg_thigh   = THIGH_RESET;

   // directed sample temperatures for the reset range
   logic [TEMP_W-1:0] t_list [10] = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001,
                                      16'd6500, 16'd39999, 16'd40000, 16'd40001, 16'hFFFF};

   // Q4.16 log2 by repeated squaring
   function automatic logic [31:0] kelvin_log2(input logic [TEMP_W-1:0] x);
      int unsigned lead;
      logic [63:0] mant;
      logic [15:0] frac;
      lead = 0;
      frac = '0;
      if (x == 0) return 0;
      for (int i = 1; i < TEMP_W; i++) if (x[i]) lead = i;
      mant = 64'(x) << (16 - lead);
      for (int i = 0; i < 16; i++) begin
         mant = (mant * mant) >> 16;
         frac = {frac[14:0], 1'b0};
         if (mant >= 64'(1 << 17)) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return (lead << 16) | frac;
   endfunction

   // apply one accepted transfer to the shadow table or predict its color
   task automatic predict_color(input lut_item_type it);
      logic [31:0] llo, lhi, lt;
      logic [63:0] pos, a, b;
      int unsigned lower, upper, weight, last;
      logic [TEMP_W-1:0] t;
      logic [CHAN_W-1:0] ch [3];
      color_type c;
      if (it.kind == KIND_LOAD) begin
         shadow_table[it.index][0] = it.red;
         shadow_table[it.index][1] = it.green;
         shadow_table[it.index][2] = it.blue;
         return;
      end
      llo = kelvin_log2(cfg_tlow);
      lhi = kelvin_log2(cfg_thigh);
      if (cfg_entries < 2 || cfg_entries > DEPTH || cfg_tlow == 0 ||
          cfg_thigh <= cfg_tlow || lhi <= llo) begin
         c = '{WHITE_LEVEL, WHITE_LEVEL, WHITE_LEVEL, 1'b1};
         color_q.push_back(c);
         return;
      end
      t = it.temp;
      if (t < cfg_tlow) t = cfg_tlow;
      if (t > cfg_thigh) t = cfg_thigh;
      lt = kelvin_log2(t);
      last = cfg_entries - 1;
      pos = ((64'(lt - llo) * 64'(last)) << 16) / 64'(lhi - llo);
      lower = pos >> 16;
      if (lower > last) lower = last;
      weight = pos & 64'hFFFF;
      upper = (lower + 1 > last) ? last : lower + 1;
      for (int k = 0; k < 3; k++) begin
         a = shadow_table[lower][k];
         b = shadow_table[upper][k];
         ch[k] = CHAN_W'((a * (65536 - weight) + b * weight) >> 16);
      end
      c = '{ch[0], ch[1], ch[2], 1'b0};
      color_q.push_back(c);
   endtask

   // acceptance: a transfer happens when start is high and busy is low
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         predict_color(pending_q[0]);
         void'(pending_q.pop_front());
      end
   end

   // driver: present the oldest pending item, idling at random
   always @(negedge clock) begin
      if (!reset && pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
         start           <= 1'b1;
         req_kind        <= pending_q[0].kind;
         req_entry_index <= pending_q[0].index;
         req_entry_red   <= pending_q[0].red;
         req_entry_green <= pending_q[0].green;
         req_entry_blue  <= pending_q[0].blue;
         req_temperature <= pending_q[0].temp;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: compare each result with the oldest expected color
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (color_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h %h %h %b",
               rsp_red, rsp_green, rsp_blue, rsp_fallback_white);
         end else begin
            if (rsp_red !== color_q[0].red || rsp_green !== color_q[0].green ||
                rsp_blue !== color_q[0].blue || rsp_fallback_white !== color_q[0].white) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                     color_q[0].red, color_q[0].green, color_q[0].blue, color_q[0].white,
                     rsp_red, rsp_green, rsp_blue, rsp_fallback_white);
            end
            void'(color_q.pop_front());
         end
      end
   end

   // register write: setup then access cycle
   task automatic csr_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_ENTRIES: cfg_entries = value[ENTRIES_W-1:0];
         REG_TLOW:    cfg_tlow    = value[TEMP_W-1:0];
         default:     cfg_thigh   = value[TEMP_W-1:0];
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic push_load(input int idx, input logic [CHAN_W-1:0] r,
                            input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
      lut_item_type it;
      it = '{KIND_LOAD, INDEX_W'(idx), r, g, b, TEMP_W'($urandom)};
      pending_q.push_back(it);
   endtask

   task automatic push_sample(input logic [TEMP_W-1:0] t);
      lut_item_type it;
      it = '{KIND_SAMPLE, INDEX_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
             CHAN_W'($urandom), t};
      pending_q.push_back(it);
   endtask

   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return WHITE_LEVEL;
         2: return CHAN_W'($urandom);
         default: return CHAN_W'($urandom_range(32768));
      endcase
   endfunction

   // wait until every expected color has arrived and the pipeline is empty
   task automatic drain();
      wait (pending_q.size() == 0);
      wait (color_q.size() == 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   // stimulus and phase sequencing
   initial begin
      int setting [11][3];
      logic [TEMP_W-1:0] t;
      setting = '{'{256, 1000, 40000}, '{2, 1, 65535}, '{256, 1, 65535},
                  '{0, 1000, 40000}, '{1, 1000, 40000}, '{511, 100, 200},
                  '{100, 65534, 65535}, '{37, 5000, 4000}, '{128, 2, 3},
                  '{64, 0, 30000}, '{256, 800, 12000}};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole table so no sample can read an unwritten entry
      for (int i = 0; i < DEPTH; i++) push_load(i, rand_chan(), rand_chan(), rand_chan());
      // directed: range edges, extreme colors, ends of the table
      push_load(0, 16'd0, 16'd0, 16'd0);
      push_load(255, 16'hFFFF, WHITE_LEVEL, 16'h0001);
      push_load(1, WHITE_LEVEL, 16'hFFFF, 16'd0);
      foreach (t_list[i]) push_sample(t_list[i]);
      drain();

      for (int p = 0; p < 11; p++) begin
         idle_pct = (p < 4) ? 10 : (p < 8) ? 72 : 0;
         csr_write(REG_ENTRIES, setting[p][0]);
         csr_write(REG_TLOW, setting[p][1]);
         csr_write(REG_THIGH, setting[p][2]);
         push_sample(TEMP_W'(setting[p][1]));
         push_sample(TEMP_W'(setting[p][2]));
         for (int n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(7) == 0) begin
               push_load($urandom_range(255), rand_chan(), rand_chan(), rand_chan());
            end else begin
               case ($urandom_range(3))
                  0: t = TEMP_W'($urandom);
                  default: t = TEMP_W'($urandom_range(setting[p][2], setting[p][1]));
               endcase
               push_sample(t);
            end
         end
         drain();
      end

      if (errors == 0 && color_q.size() == 0)
         $display("blackbody_color_lut_sampler_top_tb: done, clean");
      else
         $display("blackbody_color_lut_sampler_top_tb: done, errors");
      $finish;
   end

   // run limit
   initial begin
      #3ms;
      $display("blackbody_color_lut_sampler_top_tb: done, errors");
      $finish;
   end

endmodule
